// ----- hw/rtl/smt_pkg.sv -----
// ----------------------------------------------------------------------------
// smt_pkg
// Shared types and constants of the sorted multiset table.
// ----------------------------------------------------------------------------
package smt_pkg;

  // table capacity and derived widths
  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  // value reported for min and max of an empty table
  localparam logic [VALUE_W-1:0] EMPTY_MARK = '1;

  // status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DEDUP  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // result of one operation, engine to output stage
  typedef struct packed {
    logic               status;
    logic [CNT_W-1:0]   count;
    logic [VALUE_W-1:0] min_value;
    logic [VALUE_W-1:0] max_value;
  } res_t;

endpackage

// ----- hw/rtl/sorted_multiset_table_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_multiset_table_unit
// Ascending sorted table of signed values with insert, delete-all and dedup.
// ----------------------------------------------------------------------------
// The table lives in one memory with a single registered read port. Insert,
// delete-all and dedup walk it one entry per cycle; an insert moves up every
// entry not smaller than the value. A full-table insert, an unused op code
// and a delete or dedup on an empty table go straight to the result without
// a memory access. One item is worked on at a time; the result sits in an
// output register, so the next item is taken while an earlier result waits
// for transfer. Min and max read as all ones when the table is empty.
module sorted_multiset_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  // operation channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [4:0]  out_entry_count,
  output logic        out_is_empty,
  output logic [31:0] out_min_value,
  output logic [31:0] out_max_value
);

  logic                        mem_we;
  logic [smt_pkg::IDX_W-1:0]   mem_waddr;
  logic [smt_pkg::VALUE_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [smt_pkg::IDX_W-1:0]   mem_raddr;
  logic [smt_pkg::VALUE_W-1:0] mem_rdata;
  logic                        res_valid;
  smt_pkg::res_t               res;
  logic                        out_free;
  logic                        out_load;
  logic                        out_valid_r;
  logic                        res_empty;

  // table storage
  smt_ram #(
    .DEPTH_P (smt_pkg::DEPTH),
    .WIDTH_P (smt_pkg::VALUE_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // operation sequencer
  smt_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (smt_pkg::op_t'(in_op)),
    .in_value  (in_value),
    .in_stall  (in_stall),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free)
  );

  // output register loads when empty or when its content transfers
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = res_valid && out_free;
  assign res_empty = (res.count == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status      <= res.status;
      out_entry_count <= smt_pkg::COUNT_W'(res.count);
      out_is_empty    <= res_empty;
      out_min_value   <= res_empty ? smt_pkg::EMPTY_MARK : res.min_value;
      out_max_value   <= res_empty ? smt_pkg::EMPTY_MARK : res.max_value;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/smt_ram.sv -----
// ----------------------------------------------------------------------------
// smt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module smt_ram #(
  parameter int DEPTH_P = 16,
  parameter int WIDTH_P = 32,
  parameter int ADDR_W  = $clog2(DEPTH_P)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [WIDTH_P-1:0] wr_data,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [WIDTH_P-1:0] rd_data
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/smt_engine.sv -----
// ----------------------------------------------------------------------------
// smt_engine
// Sequencer that walks the table memory for insert, delete-all and dedup.
// ----------------------------------------------------------------------------
module smt_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  // operation input
  input  logic                        in_valid,
  input  smt_pkg::op_t                in_op,
  input  logic [smt_pkg::VALUE_W-1:0] in_value,
  output logic                        in_stall,
  // table memory
  output logic                        mem_we,
  output logic [smt_pkg::IDX_W-1:0]   mem_waddr,
  output logic [smt_pkg::VALUE_W-1:0] mem_wdata,
  output logic                        mem_re,
  output logic [smt_pkg::IDX_W-1:0]   mem_raddr,
  input  logic [smt_pkg::VALUE_W-1:0] mem_rdata,
  // result to output stage
  output logic                        res_valid,
  output smt_pkg::res_t               res,
  input  logic                        out_free
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS,
    ST_SCAN,
    ST_DONE
  } state_t;

  localparam int IDX_W = smt_pkg::IDX_W;
  localparam int CNT_W = smt_pkg::CNT_W;

  state_t                        state_r, state_nxt;
  smt_pkg::op_t                  op_r, op_nxt;
  logic [smt_pkg::VALUE_W-1:0]   val_r, val_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [smt_pkg::VALUE_W-1:0]   min_r, min_nxt;
  logic [smt_pkg::VALUE_W-1:0]   max_r, max_nxt;
  logic [smt_pkg::VALUE_W-1:0]   last_r, last_nxt;
  logic                          status_r, status_nxt;
  logic [CNT_W-1:0]              pos_r, pos_nxt;
  logic [CNT_W-1:0]              rd_r, rd_nxt;
  logic                          vld_r, vld_nxt;
  logic                          keep;
  logic [CNT_W-1:0]              wr_after;

  // sequencing and memory access
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    cnt_nxt    = cnt_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    last_nxt   = last_r;
    status_nxt = status_r;
    pos_nxt    = pos_r;
    rd_nxt     = rd_r;
    vld_nxt    = vld_r;
    mem_we     = 1'b0;
    mem_waddr  = IDX_W'(pos_r);
    mem_wdata  = val_r;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    keep       = 1'b0;
    wr_after   = pos_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_op;
          val_nxt    = in_value;
          status_nxt = smt_pkg::STATUS_OK;
          case (in_op)
            smt_pkg::OP_INSERT: begin
              if (cnt_r >= CNT_W'(smt_pkg::DEPTH)) begin
                status_nxt = smt_pkg::STATUS_FULL;
                state_nxt  = ST_DONE;
              end else begin
                pos_nxt   = cnt_r;
                state_nxt = ST_INS;
                if (cnt_r != '0) begin
                  mem_re    = 1'b1;
                  mem_raddr = IDX_W'(cnt_r - CNT_W'(1));
                  vld_nxt   = 1'b1;
                end else begin
                  vld_nxt = 1'b0;
                end
                if (cnt_r == '0 || $signed(in_value) < $signed(min_r)) begin
                  min_nxt = in_value;
                end
                if (cnt_r == '0 || $signed(in_value) >= $signed(max_r)) begin
                  max_nxt = in_value;
                end
              end
            end
            smt_pkg::OP_DELETE, smt_pkg::OP_DEDUP: begin
              if (cnt_r == '0) begin
                state_nxt = ST_DONE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                rd_nxt    = CNT_W'(1);
                pos_nxt   = '0;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // walk down from the top, shifting entries not smaller than the value
      ST_INS: begin
        mem_we = 1'b1;
        if (vld_r && $signed(val_r) <= $signed(mem_rdata)) begin
          mem_wdata = mem_rdata;
          pos_nxt   = pos_r - CNT_W'(1);
          if (pos_r == CNT_W'(1)) begin
            vld_nxt = 1'b0;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = IDX_W'(pos_r - CNT_W'(2));
            vld_nxt   = 1'b1;
          end
        end else begin
          mem_wdata = val_r;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = ST_DONE;
        end
      end

      // stream entries upward, keeping the ones that survive
      ST_SCAN: begin
        if (op_r == smt_pkg::OP_DEDUP) begin
          keep = (pos_r == '0) || (mem_rdata != last_r);
        end else begin
          keep = (mem_rdata != val_r);
        end
        if (keep) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          last_nxt  = mem_rdata;
          max_nxt   = mem_rdata;
          if (pos_r == '0) begin
            min_nxt = mem_rdata;
          end
          wr_after = pos_r + CNT_W'(1);
        end
        pos_nxt = wr_after;
        if (rd_r < cnt_r) begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(rd_r);
          rd_nxt    = rd_r + CNT_W'(1);
        end else begin
          cnt_nxt   = wr_after;
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      vld_r   <= vld_nxt;
    end
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    min_r    <= min_nxt;
    max_r    <= max_nxt;
    last_r   <= last_nxt;
    status_r <= status_nxt;
    pos_r    <= pos_nxt;
    rd_r     <= rd_nxt;
  end

  // handshake and result
  assign in_stall      = (state_r != ST_IDLE);
  assign res_valid     = (state_r == ST_DONE);
  assign res.status    = status_r;
  assign res.count     = cnt_r;
  assign res.min_value = min_r;
  assign res.max_value = max_r;

  // count never exceeds the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(smt_pkg::DEPTH))
    else $error("entry count above capacity");

  // compaction never writes at or above the entry being read
  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && mem_we) |-> (pos_r < rd_r))
    else $error("compaction write overtakes read");

  // a finished insert adds exactly one entry
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS && state_nxt == ST_DONE) |=>
      (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("insert did not add one entry");

  // a result waits until the output stage takes it
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_free) |=> (state_r == ST_DONE))
    else $error("result dropped while output busy");

  // min and max stay ordered while the table is idle and not empty
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && cnt_r != '0) |-> ($signed(min_r) <= $signed(max_r)))
    else $error("min above max");

endmodule

// ----- verif/sorted_multiset_table_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_multiset_table_unit_test
// Self-checking bench for the sorted multiset table unit. A table tracker
// applies every accepted operation to its own sorted copy of the table and
// queues the status, count, empty flag, min and max that the block must
// return. Results are compared field by field in order. Stimulus is a short
// directed run followed by random fill and drain phases, with bursty input,
// patterned output stall and one long output hold-off.
// ----------------------------------------------------------------------------

// one result as seen on the result channel
typedef struct packed {
  logic                        status;
  logic [smt_pkg::COUNT_W-1:0] count;
  logic                        empty;
  logic [smt_pkg::VALUE_W-1:0] min_value;
  logic [smt_pkg::VALUE_W-1:0] max_value;
} table_result_t;

// tracks the table contents and the results still owed by the block
class table_scoreboard;
  logic [smt_pkg::VALUE_W-1:0] held[smt_pkg::DEPTH];
  int                          fill;
  table_result_t               awaited[$];
  int unsigned                 failures;
  int unsigned                 reported;

  function new();
    fill     = 0;
    failures = 0;
    reported = 0;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  // random entry currently in the table, or any value when empty
  function logic [smt_pkg::VALUE_W-1:0] pick_held();
    if (fill == 0) return $urandom;
    return held[$urandom_range(0, fill - 1)];
  endfunction

  // apply one accepted operation and queue its result
  function void note_op(smt_pkg::op_t op, logic [smt_pkg::VALUE_W-1:0] v);
    table_result_t r;
    int pos;
    int wr;
    int i;
    r.status = smt_pkg::STATUS_OK;
    case (op)
      smt_pkg::OP_INSERT: begin
        if (fill >= smt_pkg::DEPTH) begin
          r.status = smt_pkg::STATUS_FULL;
        end else begin
          // first slot whose entry is not smaller than the value
          pos = 0;
          while (pos < fill && $signed(v) > $signed(held[pos])) pos++;
          for (i = fill; i > pos; i--) held[i] = held[i - 1];
          held[pos] = v;
          fill++;
        end
      end
      smt_pkg::OP_DELETE: begin
        wr = 0;
        for (i = 0; i < fill; i++) begin
          if (held[i] != v) begin
            held[wr] = held[i];
            wr++;
          end
        end
        fill = wr;
      end
      smt_pkg::OP_DEDUP: begin
        if (fill > 0) begin
          wr = 1;
          for (i = 1; i < fill; i++) begin
            if (held[i] != held[wr - 1]) begin
              held[wr] = held[i];
              wr++;
            end
          end
          fill = wr;
        end
      end
      default: ;
    endcase
    r.count     = smt_pkg::COUNT_W'(fill);
    r.empty     = (fill == 0);
    r.min_value = (fill == 0) ? smt_pkg::EMPTY_MARK : held[0];
    r.max_value = (fill == 0) ? smt_pkg::EMPTY_MARK : held[fill - 1];
    awaited.push_back(r);
  endfunction

  function void flag(string msg);
    failures++;
    if (reported < 10) begin
      reported++;
      $display("mismatch: %s", msg);
    end
  endfunction

  function void compare_field(string name, logic [smt_pkg::VALUE_W-1:0] want,
                              logic [smt_pkg::VALUE_W-1:0] got);
    if (got !== want)
      flag($sformatf("%s expected %h actual %h", name, want, got));
  endfunction

  // compare one transferred result with the oldest one owed
  function void check_result(table_result_t got);
    table_result_t want;
    if (awaited.size() == 0) begin
      flag($sformatf("result with nothing pending, count %0d", got.count));
      return;
    end
    want = awaited.pop_front();
    compare_field("status", smt_pkg::VALUE_W'(want.status),
                  smt_pkg::VALUE_W'(got.status));
    compare_field("entry_count", smt_pkg::VALUE_W'(want.count),
                  smt_pkg::VALUE_W'(got.count));
    compare_field("is_empty", smt_pkg::VALUE_W'(want.empty),
                  smt_pkg::VALUE_W'(got.empty));
    compare_field("min_value", want.min_value, got.min_value);
    compare_field("max_value", want.max_value, got.max_value);
  endfunction
endclass

module sorted_multiset_table_unit_test;

  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 200;
  localparam int HOLD_AFTER   = 60;
  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [smt_pkg::VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [smt_pkg::VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [smt_pkg::VALUE_W-1:0] VAL_NEG = 32'hffff_ffff;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_op;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_stall;
  logic        out_status;
  logic [4:0]  out_entry_count;
  logic        out_is_empty;
  logic [31:0] out_min_value;
  logic [31:0] out_max_value;

  table_scoreboard             expected_table;
  int unsigned                 ops_taken;
  int                          burst_left;
  logic [smt_pkg::VALUE_W-1:0] value_pool[6];

  sorted_multiset_table_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_min_value   (out_min_value),
    .out_max_value   (out_max_value)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // monitor both channels; results are checked before the new op is noted
  always @(posedge clk) begin
    table_result_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.status    = out_status;
      seen.count     = out_entry_count;
      seen.empty     = out_is_empty;
      seen.min_value = out_min_value;
      seen.max_value = out_max_value;
      expected_table.check_result(seen);
    end
    if (rst_n && in_valid && !in_stall) begin
      expected_table.note_op(smt_pkg::op_t'(in_op), in_value);
      ops_taken++;
    end
  end

  // watchdog on cycles without any transfer
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // result side stall: random segments of varying density, one long hold
  initial begin : receiver
    int hold_left;
    int seg_left;
    int pct;
    bit hold_done;
    hold_left = 0;
    seg_left  = 0;
    pct       = 0;
    hold_done = 0;
    out_stall = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && ops_taken >= HOLD_AFTER) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(5, 60);
          case ($urandom_range(0, 3))
            0: pct = 0;
            1: pct = 25;
            2: pct = 60;
            default: pct = 90;
          endcase
        end
        seg_left--;
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // offer one op and wait for its transfer; bursts end with a random gap
  task automatic send_op(smt_pkg::op_t op, logic [smt_pkg::VALUE_W-1:0] v);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // operand: mostly a small pool so duplicates and hits are common
  function automatic logic [smt_pkg::VALUE_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return value_pool[$urandom_range(0, 5)];
    if (roll < 85) return $urandom;
    case ($urandom_range(0, 3))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return VAL_NEG;
      default: return '0;
    endcase
  endfunction

  // reset, directed run, random fill and drain phases, drain and verdict
  initial begin : stimulus
    bit                          filling;
    int                          phase_left;
    int                          roll;
    smt_pkg::op_t                op;
    logic [smt_pkg::VALUE_W-1:0] v;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_op      = smt_pkg::OP_INSERT;
    in_value   = '0;
    ops_taken  = 0;
    burst_left = 0;
    expected_table = new();
    foreach (value_pool[i]) value_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty table corner cases and the unused code
    send_op(smt_pkg::OP_DELETE, 32'd5);
    send_op(smt_pkg::OP_DEDUP, '0);
    send_op(smt_pkg::OP_NOP, VAL_NEG);
    // extremes and duplicates
    send_op(smt_pkg::OP_INSERT, '0);
    send_op(smt_pkg::OP_INSERT, VAL_MAX);
    send_op(smt_pkg::OP_INSERT, VAL_MIN);
    send_op(smt_pkg::OP_INSERT, '0);
    send_op(smt_pkg::OP_INSERT, VAL_NEG);
    send_op(smt_pkg::OP_INSERT, VAL_MAX);
    send_op(smt_pkg::OP_INSERT, 32'd1);
    send_op(smt_pkg::OP_DEDUP, VAL_NEG);
    // absent value, then every entry removed
    send_op(smt_pkg::OP_DELETE, 32'd7);
    send_op(smt_pkg::OP_DELETE, '0);
    send_op(smt_pkg::OP_INSERT, '0);
    send_op(smt_pkg::OP_INSERT, '0);
    send_op(smt_pkg::OP_DELETE, '0);
    send_op(smt_pkg::OP_DELETE, VAL_MIN);
    send_op(smt_pkg::OP_DELETE, VAL_MAX);
    send_op(smt_pkg::OP_DELETE, VAL_NEG);
    send_op(smt_pkg::OP_DELETE, 32'd1);
    send_op(smt_pkg::OP_NOP, '0);

    // alternate insert heavy and delete heavy phases
    filling    = 0;
    phase_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = $urandom_range(20, 50);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (filling) begin
        if (roll < 82) op = smt_pkg::OP_INSERT;
        else if (roll < 90) op = smt_pkg::OP_DELETE;
        else if (roll < 95) op = smt_pkg::OP_DEDUP;
        else op = smt_pkg::OP_NOP;
      end else begin
        if (roll < 60) op = smt_pkg::OP_DELETE;
        else if (roll < 82) op = smt_pkg::OP_INSERT;
        else if (roll < 95) op = smt_pkg::OP_DEDUP;
        else op = smt_pkg::OP_NOP;
      end
      if (op == smt_pkg::OP_DELETE && $urandom_range(0, 99) < 80)
        v = expected_table.pick_held();
      else
        v = pick_value();
      send_op(op, v);
    end
    in_valid <= 1'b0;

    // let the monitor note the last transfer, wait for every owed result,
    // then watch for stray ones
    @(posedge clk);
    while (expected_table.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_table.failures == 0 && expected_table.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- sorted_multiset_table_unit.f -----
hw/rtl/smt_pkg.sv
hw/rtl/smt_ram.sv
hw/rtl/smt_engine.sv
hw/rtl/sorted_multiset_table_unit.sv
verif/sorted_multiset_table_unit_test.sv
